FILE: rtl/timed_event_queue_defines.svh
// ----------------------------------------------------------------------------
// timed event queue assertion macros
// concurrent checks on the queue clock, switched off for synthesis
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_QUEUE_DEFINES_SVH
`define TIMED_EVENT_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define TEQ_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// condition must never hold
`define TEQ_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);
`else
`define TEQ_ASSERT_IMPLIES(label, ante, cons, msg)
`define TEQ_ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: rtl/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// shared types and constants of the timed event queue
// ----------------------------------------------------------------------------
package teq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_SENT    = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int SENT_W      = $clog2(MAX_SENT + 1);
   localparam int TYPE_W      = 16;
   localparam int TARGET_W    = 16;
   localparam int TIME_W      = 32;
   localparam int KIND_W      = 3;
   localparam int HELD_W      = 5;

   typedef enum logic [1:0] {
      OP_ENQUEUE  = 2'd0,
      OP_DISPATCH = 2'd1,
      OP_PURGE    = 2'd2
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DONE = 3'd0,
      KIND_SENT = 3'd1,
      KIND_FULL = 3'd2,
      KIND_NULL = 3'd3
   } kind_type;

   typedef struct packed {
      op_type              op;
      logic [TIME_W-1:0]   now_time;
      logic [TYPE_W-1:0]   event_type;
      logic [TARGET_W-1:0] target_id;
      logic [TIME_W-1:0]   delay_ticks;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      logic [TYPE_W-1:0]   out_event_type;
      logic [TARGET_W-1:0] out_target_id;
      logic [HELD_W-1:0]   entries_held;
      logic                last;
   } rsp_type;

   // one queue entry as held by a cell
   typedef struct packed {
      logic [TYPE_W-1:0]   event_type;
      logic [TARGET_W-1:0] target_id;
      logic [TIME_W-1:0]   due_time;
      logic                sent;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_LOAD,
      CELL_PURGE
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [TARGET_W-1:0] purge_target;
   } cell_ctl_type;

endpackage

FILE: rtl/teq_cell.sv
// ----------------------------------------------------------------------------
// teq_cell
// one queue slot: holds, takes its neighbor, loads the bus or purges
// ----------------------------------------------------------------------------
module teq_cell import teq_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  entry_type    next_entry,
   input  entry_type    bus_entry,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         CELL_HOLD:  entry_in = entry_ff;
         CELL_SHIFT: entry_in = next_entry;
         CELL_LOAD:  entry_in = bus_entry;
         CELL_PURGE: begin
            if (entry_ff.target_id == ctl.purge_target) begin
               entry_in.target_id  = '0;
               entry_in.event_type = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/timed_event_queue.sv
// ----------------------------------------------------------------------------
// timed_event_queue
// ordered queue of delayed events kept in a chain of shifting cells
// ----------------------------------------------------------------------------
//
//  channel   ports                       direction  flow
//  request   start, busy, req_word       in         taken when start and not busy
//  result    rsp_valid, rsp_word         out        each word valid for one cycle, no stall
//
// enqueue, purge and the unused opcode give their word in the cycle after
// they are taken; the block is ready again at once
// dispatch on a non-empty queue makes a marking rotation through the
// cell chain, then an emitting rotation that sends marked entries and
// compacts the rest
// reset is synchronous and empties the queue; slots keep no valid bits
// the result side cannot stall, each word shows for exactly one cycle
//
`include "timed_event_queue_defines.svh"

module timed_event_queue import teq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_word,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_word
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;       // entries held
   logic [CNT_W-1:0]   remain_ff, remain_in;     // entries still to rotate
   logic [CNT_W-1:0]   keep_total_ff, keep_total_in;
   logic [CNT_W-1:0]   kept_ff, kept_in;         // kept so far in emit pass
   logic [SENT_W-1:0]  sent_ff, sent_in;
   logic [SENT_W-1:0]  emit_no_ff, emit_no_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // cell chain: cell 0 is the queue head, data moves toward it
   entry_type          cell_q   [QUEUE_DEPTH];
   entry_type          next_q   [QUEUE_DEPTH];
   cell_ctl_type       cell_ctl [QUEUE_DEPTH];
   entry_type          bus_entry;

   entry_type          head;
   logic               head_due;
   logic               head_live;
   logic               send_now;
   logic               kept_now;
   logic [CNT_W-1:0]   write_pos;
   logic [CNT_W-1:0]   tail_pos;

   // terms for the checks
   logic               in_mark;
   logic               in_emit;
   logic               sent_word;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_q[i] = cell_q[i];
      end else begin : g_mid
         assign next_q[i] = cell_q[i + 1];
      end

      teq_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .next_entry (next_q[i]),
         .bus_entry  (bus_entry),
         .entry      (cell_q[i])
      );
   end

   // head inspection, one due compare used by the marking pass
   assign head      = cell_q[0];
   assign head_due  = (head.due_time == '0) || (head.due_time < now_ff);
   assign head_live = (head.target_id != '0);
   assign send_now  = head_due && head_live && (sent_ff < SENT_W'(MAX_SENT));
   assign kept_now  = !head.sent && head_live && (head.event_type != '0);
   // kept entries sit behind the unrotated ones, the newest one lands here
   assign write_pos = remain_ff + kept_ff - CNT_W'(1);
   assign tail_pos  = count_ff - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      keep_total_in = keep_total_ff;
      kept_in       = kept_ff;
      sent_in       = sent_ff;
      emit_no_in    = emit_no_ff;
      now_in        = now_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      bus_entry     = head;

      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         cell_ctl[i].op           = CELL_HOLD;
         cell_ctl[i].purge_target = req_word.target_id;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               now_in                = req_word.now_time;
               rsp_in.kind           = KIND_DONE;
               rsp_in.out_event_type = '0;
               rsp_in.out_target_id  = '0;
               rsp_in.entries_held   = HELD_W'(count_ff);
               rsp_in.last           = 1'b1;
               unique case (req_word.op)
                  OP_ENQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (req_word.target_id == '0) begin
                        rsp_in.kind = KIND_NULL;
                     end else if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                        rsp_in.kind = KIND_FULL;
                     end else begin
                        bus_entry.event_type = req_word.event_type;
                        bus_entry.target_id  = req_word.target_id;
                        bus_entry.due_time   = (req_word.delay_ticks != '0) ?
                           TIME_W'(req_word.now_time + req_word.delay_ticks) : '0;
                        bus_entry.sent       = 1'b0;
                        for (int i = 0; i < QUEUE_DEPTH; i++) begin
                           if (count_ff == CNT_W'(i)) begin
                              cell_ctl[i].op = CELL_LOAD;
                           end
                        end
                        count_in            = count_ff + CNT_W'(1);
                        rsp_in.entries_held = HELD_W'(count_ff + CNT_W'(1));
                     end
                  end
                  OP_DISPATCH: begin
                     if (count_ff == '0) begin
                        // empty queue, nothing can be due
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in      = ST_MARK;
                        remain_in     = count_ff;
                        sent_in       = '0;
                        keep_total_in = '0;
                     end
                  end
                  OP_PURGE: begin
                     rsp_valid_in = 1'b1;
                     for (int i = 0; i < QUEUE_DEPTH; i++) begin
                        cell_ctl[i].op = CELL_PURGE;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_MARK: begin
            // full rotation: tag what is sent and count what survives
            bus_entry.sent = send_now;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               cell_ctl[i].op = (CNT_W'(i) == tail_pos) ? CELL_LOAD : CELL_SHIFT;
            end
            sent_in       = sent_ff + SENT_W'(send_now);
            keep_total_in = keep_total_ff +
               CNT_W'(head_live && !send_now && (head.event_type != '0));
            remain_in     = remain_ff - CNT_W'(1);
            if (remain_ff == CNT_W'(1)) begin
               state_in   = ST_EMIT;
               remain_in  = count_ff;
               kept_in    = '0;
               emit_no_in = '0;
            end
         end

         ST_EMIT: begin
            // second rotation: send tagged entries, keep only live untagged ones with a type
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               cell_ctl[i].op = (kept_now && (CNT_W'(i) == write_pos)) ?
                  CELL_LOAD : CELL_SHIFT;
            end
            if (head.sent) begin
               rsp_valid_in          = 1'b1;
               rsp_in.kind           = KIND_SENT;
               rsp_in.out_event_type = head.event_type;
               rsp_in.out_target_id  = head.target_id;
               rsp_in.entries_held   = HELD_W'(keep_total_ff);
               rsp_in.last           = (emit_no_ff + SENT_W'(1) == sent_ff);
               emit_no_in            = emit_no_ff + SENT_W'(1);
            end
            kept_in   = kept_ff + CNT_W'(kept_now);
            remain_in = remain_ff - CNT_W'(1);
            if (remain_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
               count_in = keep_total_ff;
               if (sent_ff == '0) begin
                  // nothing was due: one closing word
                  rsp_valid_in          = 1'b1;
                  rsp_in.kind           = KIND_DONE;
                  rsp_in.out_event_type = '0;
                  rsp_in.out_target_id  = '0;
                  rsp_in.entries_held   = HELD_W'(keep_total_ff);
                  rsp_in.last           = 1'b1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         remain_ff     <= '0;
         keep_total_ff <= '0;
         kept_ff       <= '0;
         sent_ff       <= '0;
         emit_no_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         remain_ff     <= remain_in;
         keep_total_ff <= keep_total_in;
         kept_ff       <= kept_in;
         sent_ff       <= sent_in;
         emit_no_ff    <= emit_no_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      now_ff <= now_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // checks
   assign in_mark   = (state_ff == ST_MARK);
   assign in_emit   = (state_ff == ST_EMIT);
   assign sent_word = rsp_valid_ff && (rsp_ff.kind == KIND_SENT);

   `TEQ_ASSERT_NEVER(a_count_bound, count_ff > CNT_W'(QUEUE_DEPTH), "queue count over depth")
   `TEQ_ASSERT_IMPLIES(a_keep_bound, in_emit, keep_total_ff <= count_ff, "kept over held")
   `TEQ_ASSERT_IMPLIES(a_sent_bound, in_mark, sent_ff <= SENT_W'(MAX_SENT), "sent over limit")
   `TEQ_ASSERT_IMPLIES(a_sent_word, sent_word, $past(in_emit), "event word outside emit pass")

endmodule

FILE: tb/tb_timed_event_queue.sv
// ----------------------------------------------------------------------------
// tb_timed_event_queue
// self-checking bench for the timed event queue: a mirror of the queue
// predicts every result word from the accepted request words, directed
// corner cases come first, then random traffic in bursts
// ----------------------------------------------------------------------------
module tb_timed_event_queue;
   import teq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLK_PERIOD   = 10;
   localparam int          RESET_CYCLES = 3;
   localparam int          RANDOM_WORDS = 450;
   localparam int          DRAIN_CYCLES = 4 * QUEUE_DEPTH + 8;
   localparam int          MAX_REPORTS  = 10;
   localparam longint      TIMEOUT_NS   = 2_000_000;
   // opcode outside the enum, must behave as a no-op
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   // small handle pool so purges hit live entries
   localparam int          POOL_SIZE    = 6;

   // --------------------------------------------------------------------------
   // mirror of the queue contents and the result words it must produce
   // --------------------------------------------------------------------------
   class event_queue_mirror;
      logic [TYPE_W-1:0]   slot_event [QUEUE_DEPTH];
      logic [TARGET_W-1:0] slot_target[QUEUE_DEPTH];
      logic [TIME_W-1:0]   slot_due   [QUEUE_DEPTH];
      int                  held;
      rsp_type             pending_replies[$];
      int                  failures;

      function new();
         held     = 0;
         failures = 0;
      endfunction

      function void push_reply(kind_type kind, logic [TYPE_W-1:0] ev,
                               logic [TARGET_W-1:0] tgt, logic is_last);
         rsp_type w;
         w.kind           = kind;
         w.out_event_type = ev;
         w.out_target_id  = tgt;
         w.entries_held   = HELD_W'(held);
         w.last           = is_last;
         pending_replies.push_back(w);
      endfunction

      // update the mirror for one accepted request word, queue its results
      function void take_request(req_type r);
         logic [TYPE_W-1:0]   sent_event[$];
         logic [TARGET_W-1:0] sent_target[$];
         int                  keep;
         logic                is_due;
         case (r.op)
            OP_ENQUEUE: begin
               if (r.target_id == '0) begin
                  push_reply(KIND_NULL, '0, '0, 1'b1);
               end else if (held >= QUEUE_DEPTH) begin
                  push_reply(KIND_FULL, '0, '0, 1'b1);
               end else begin
                  slot_event[held]  = r.event_type;
                  slot_target[held] = r.target_id;
                  // zero delay means due at once, otherwise wraps mod 2^32
                  slot_due[held]    = (r.delay_ticks == '0) ? '0 :
                                      TIME_W'(r.now_time + r.delay_ticks);
                  held++;
                  push_reply(KIND_DONE, '0, '0, 1'b1);
               end
            end
            OP_DISPATCH: begin
               for (int i = 0; i < held && sent_event.size() < MAX_SENT; i++) begin
                  is_due = (slot_due[i] == '0) || (slot_due[i] < r.now_time);
                  if (is_due && slot_target[i] != '0) begin
                     sent_event.push_back(slot_event[i]);
                     sent_target.push_back(slot_target[i]);
                     slot_target[i] = '0;
                  end
               end
               // compaction drops sent, purged and typeless entries
               keep = 0;
               for (int i = 0; i < held; i++) begin
                  if (slot_target[i] != '0 && slot_event[i] != '0) begin
                     slot_event[keep]  = slot_event[i];
                     slot_target[keep] = slot_target[i];
                     slot_due[keep]    = slot_due[i];
                     keep++;
                  end
               end
               held = keep;
               if (sent_event.size() == 0) begin
                  push_reply(KIND_DONE, '0, '0, 1'b1);
               end else begin
                  foreach (sent_event[k])
                     push_reply(KIND_SENT, sent_event[k], sent_target[k],
                                k == sent_event.size() - 1);
               end
            end
            OP_PURGE: begin
               // a purge of the null handle only matches dead entries
               for (int i = 0; i < held; i++) begin
                  if (slot_target[i] == r.target_id) begin
                     slot_target[i] = '0;
                     slot_event[i]  = '0;
                  end
               end
               push_reply(KIND_DONE, '0, '0, 1'b1);
            end
            default: begin
               push_reply(KIND_DONE, '0, '0, 1'b1);
            end
         endcase
      endfunction

      // compare one result word with the oldest outstanding prediction
      function void check_reply(rsp_type got);
         rsp_type want;
         if (pending_replies.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: unexpected word kind=%0d type=%h target=%h held=%0d last=%b",
                        $realtime, got.kind, got.out_event_type, got.out_target_id,
                        got.entries_held, got.last);
            return;
         end
         want = pending_replies.pop_front();
         if (got.kind !== want.kind || got.out_event_type !== want.out_event_type ||
             got.out_target_id !== want.out_target_id ||
             got.entries_held !== want.entries_held || got.last !== want.last) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("%0t: word mismatch", $realtime);
               $display("   expected kind=%0d type=%h target=%h held=%0d last=%b",
                        want.kind, want.out_event_type, want.out_target_id,
                        want.entries_held, want.last);
               $display("   actual   kind=%0d type=%h target=%h held=%0d last=%b",
                        got.kind, got.out_event_type, got.out_target_id,
                        got.entries_held, got.last);
            end
         end
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // clock, reset and the block
   // --------------------------------------------------------------------------
   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_word = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_word;

   event_queue_mirror mirror;

   always #(CLK_PERIOD / 2) clock = ~clock;

   timed_event_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_word  (req_word),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // --------------------------------------------------------------------------
   // monitor: values read here are the ones that held before the edge, so
   // the request is noted before any of its words can show up
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            mirror.take_request(req_word);
         if (rsp_valid)
            mirror.check_reply(rsp_word);
      end
   end

   // --------------------------------------------------------------------------
   // driver tasks
   // --------------------------------------------------------------------------

   // present one request word and hold it until the block takes it
   task automatic send_word(input op_type op, input logic [TIME_W-1:0] now_t,
                            input logic [TYPE_W-1:0] ev,
                            input logic [TARGET_W-1:0] tgt,
                            input logic [TIME_W-1:0] dly);
      req_type w;
      w.op          = op;
      w.now_time    = now_t;
      w.event_type  = ev;
      w.target_id   = tgt;
      w.delay_ticks = dly;
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // stop sending until every predicted word has come back
   task automatic wait_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (mirror.pending_replies.size() != 0)
         @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------------
   initial begin : stimulus
      logic [TIME_W-1:0]   tick_now;
      logic [TIME_W-1:0]   dly;
      logic [TYPE_W-1:0]   ev;
      logic [TARGET_W-1:0] tgt;
      int                  pick;
      int                  burst_left;
      int                  gap;

      mirror = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // dispatch on an empty queue
      send_word(OP_DISPATCH, 32'd0, 16'h0000, 16'h0000, 32'd0);
      // null target is rejected
      send_word(OP_ENQUEUE, 32'd50, 16'h1234, 16'h0000, 32'd7);
      // immediate entry with all-ones type and target
      send_word(OP_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd0);
      // type none is still queued, sent when due, then compacted away
      send_word(OP_ENQUEUE, 32'd10, 16'h0000, 16'h0001, 32'd0);
      // latest possible due time
      send_word(OP_ENQUEUE, 32'd0, 16'h0001, 16'h0002, 32'hFFFF_FFFF);
      // due time wraps past 2^32 to a small value
      send_word(OP_ENQUEUE, 32'hFFFF_FFF0, 16'h0002, 16'h0003, 32'h0000_0020);
      // due at 105, not yet sent when now equals it
      send_word(OP_ENQUEUE, 32'd100, 16'h0003, 16'h0004, 32'd5);
      // overdue entry that gets purged before any dispatch
      send_word(OP_ENQUEUE, 32'd0, 16'h0004, 16'h0002, 32'd1);
      send_word(OP_PURGE, 32'd100, 16'h0000, 16'h0002, 32'd0);
      // purge of the null handle touches only dead entries
      send_word(OP_PURGE, 32'd100, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
      // unused opcode changes nothing
      send_word(op_type'(OP_UNUSED), 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      // due equal to now stays queued
      send_word(OP_DISPATCH, 32'd105, 16'h0000, 16'h0000, 32'd0);
      // fill the queue, overflow once, then send all sixteen in one go
      for (int i = 0; i < QUEUE_DEPTH - 1; i++)
         send_word(OP_ENQUEUE, 32'd106, TYPE_W'(i + 1), TARGET_W'(16'h0100 + i), 32'd0);
      send_word(OP_ENQUEUE, 32'd106, 16'h5555, 16'hAAAA, 32'd0);
      send_word(OP_DISPATCH, 32'd106, 16'h0000, 16'h0000, 32'd0);
      wait_until_drained();

      // ---- random part ----
      tick_now   = $urandom_range(1000);
      burst_left = 0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // bursts of random length with random gaps, sometimes none at all
         if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap        = ($urandom_range(99) < 30) ? 0 : $urandom_range(8, 1);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;

         // mostly a slowly advancing tick count, with jumps and wrap-arounds
         pick = $urandom_range(99);
         if (pick < 3)
            tick_now = $urandom();
         else if (pick < 5)
            tick_now = 32'hFFFF_FFFF - $urandom_range(40);
         else
            tick_now = tick_now + $urandom_range(12);

         tgt = ($urandom_range(99) < 85) ? TARGET_W'($urandom_range(POOL_SIZE, 1))
                                         : TARGET_W'($urandom());
         ev  = ($urandom_range(99) < 90) ? TYPE_W'($urandom_range(16'hFFFF, 1)) : '0;
         pick = $urandom_range(99);
         if (pick < 30)
            dly = '0;
         else if (pick < 80)
            dly = $urandom_range(30, 1);
         else if (pick < 95)
            dly = $urandom();
         else
            dly = 32'hFFFF_FFFF - $urandom_range(20);

         pick = $urandom_range(99);
         if (pick < 48)
            send_word(OP_ENQUEUE, tick_now, ev, tgt, dly);
         else if (pick < 53)
            send_word(OP_ENQUEUE, tick_now, ev, '0, dly);
         else if (pick < 78)
            // the unused fields carry noise
            send_word(OP_DISPATCH, tick_now, TYPE_W'($urandom()), TARGET_W'($urandom()),
                      $urandom());
         else if (pick < 92)
            send_word(OP_PURGE, tick_now, TYPE_W'($urandom()),
                      ($urandom_range(9) == 0) ? '0 : tgt, $urandom());
         else
            send_word(op_type'(OP_UNUSED), $urandom(), TYPE_W'($urandom()),
                      TARGET_W'($urandom()), $urandom());

         // hold off once midway until everything outstanding has come back
         if (n == RANDOM_WORDS / 2)
            wait_until_drained();
      end

      // ---- end of run ----
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.failures == 0 && mirror.pending_replies.size() == 0) begin
         $display("tb_timed_event_queue: PASS");
      end else begin
         $display("tb_timed_event_queue: FAIL");
      end
      $finish;
   end

   // watchdog against a hung handshake
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("tb_timed_event_queue: FAIL");
      $finish;
   end

endmodule
